FILE: src/dqs_pkg.sv
package dqs_pkg;

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 48;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_FRONT  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_AT    = 3'd4,
    CMD_FIND       = 3'd5
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic read_done;
    logic scan;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic need_read;
    logic need_scan;
    logic match;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/bounded_deque_with_search_unit.sv
// channel  dir  width  fields (low bit first)
// s        in   48     command[2:0] value[34:3] position[42:35]
// m        out  48     value_out[31:0] position_out[36:32] count[41:37] status[43:42]
//
// push, pop and failed reads go from accept through exec to the done state; read_at adds a read state
// find adds a scan state over up to DEPTH entries, one ring entry compared per cycle
// through the single registered read port of the ring memory
// a new request is taken once the previous one is staged; the result waits
// in the output register while the next request runs
// rst is synchronous; it empties the queue, ring contents are not cleared
module bounded_deque_with_search_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // command, value, position
  input  logic [dqs_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // value_out, position_out, count, status
  output logic [dqs_pkg::OUT_W-1:0] m_tdata
);

  dqs_pkg::ctl_t ctl;
  dqs_pkg::sts_t sts;

  dqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  dqs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ctl      (ctl),
    .sts      (sts)
  );

endmodule

FILE: src/dqs_ctrl.sv
module dqs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  dqs_pkg::sts_t sts,
  output dqs_pkg::ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        priority if (sts.need_read) begin
          state_next = S_READ;
        end else if (sts.need_scan) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        ctl.read_done = 1'b1;
        state_next    = S_DONE;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.match || sts.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/dqs_datapath.sv
module dqs_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dqs_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [dqs_pkg::OUT_W-1:0]  m_tdata,
  input  dqs_pkg::ctl_t              ctl,
  output dqs_pkg::sts_t              sts
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [2:0]    req_cmd;
  logic [31:0]   req_value;
  logic [7:0]    req_pos;
  logic [AW-1:0] scan_idx;
  logic [31:0]   rd_data;
  logic [31:0]   res_value;
  logic [4:0]    res_pos;
  logic [4:0]    res_count;
  dqs_pkg::status_t res_status;
  dqs_pkg::status_t exec_status;

  logic          full;
  logic          empty;
  logic [7:0]    pos_eff;
  logic          in_range;
  logic [AW-1:0] rd_off;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] back_addr;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  function automatic logic [AW-1:0] ring_idx(input logic [AW:0] s);
    if (s >= (AW+1)'(DEPTH)) begin
      return AW'(s - (AW+1)'(DEPTH));
    end
    return AW'(s);
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos_eff   = (req_pos == 8'd0) ? 8'd1 : req_pos;
  assign in_range  = (pos_eff <= 8'(count));
  assign rd_off    = ctl.scan ? (scan_idx + AW'(1)) :
                     (req_cmd == dqs_pkg::CMD_FIND) ? '0 : AW'(pos_eff - 8'd1);
  assign rd_addr   = ring_idx({1'b0, head} + {1'b0, rd_off});
  assign back_addr = ring_idx({1'b0, head} + (AW+1)'(count));
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  assign sts.need_read = (req_cmd == dqs_pkg::CMD_READ_AT) && !empty && in_range;
  assign sts.need_scan = (req_cmd == dqs_pkg::CMD_FIND) && !empty;
  assign sts.match     = (rd_data == req_value);
  assign sts.scan_last = ((CW'(scan_idx) + CW'(1)) == count);
  assign sts.out_free  = !m_tvalid || m_tready;

  always_comb begin
    count_next  = count;
    head_next   = head;
    wr_en       = 1'b0;
    wr_addr     = back_addr;
    exec_status = dqs_pkg::ST_OK;
    unique case (req_cmd)
      dqs_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          exec_status = dqs_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      dqs_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          exec_status = dqs_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + CW'(1);
        end
      end
      dqs_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          exec_status = dqs_pkg::ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - CW'(1);
        end
      end
      dqs_pkg::CMD_POP_BACK: begin
        if (empty) begin
          exec_status = dqs_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      dqs_pkg::CMD_READ_AT: begin
        if (empty) begin
          exec_status = dqs_pkg::ST_EMPTY;
        end else if (!in_range) begin
          exec_status = dqs_pkg::ST_NOT_FOUND;
        end
      end
      dqs_pkg::CMD_FIND: begin
        exec_status = dqs_pkg::ST_NOT_FOUND;
      end
      default: begin
        exec_status = dqs_pkg::ST_OK;
      end
    endcase
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) begin
      mem[wr_addr] <= req_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // request capture, scan index and result staging
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_cmd   <= s_tdata[2:0];
      req_value <= s_tdata[34:3];
      req_pos   <= s_tdata[42:35];
    end
    if (ctl.exec) begin
      scan_idx   <= '0;
      res_value  <= '0;
      res_pos    <= '0;
      res_count  <= 5'(count_next);
      res_status <= exec_status;
    end
    if (ctl.read_done) begin
      res_value <= rd_data;
    end
    if (ctl.scan) begin
      scan_idx <= scan_idx + AW'(1);
      if (sts.match) begin
        res_pos    <= 5'(CW'(scan_idx) + CW'(1));
        res_status <= dqs_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      m_tdata <= {4'd0, res_status, res_count, res_pos, res_value};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_push_hold: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && full &&
     (req_cmd == dqs_pkg::CMD_PUSH_BACK || req_cmd == dqs_pkg::CMD_PUSH_FRONT))
    |=> $stable(count) && $stable(head))
    else $error("push on full queue changed state");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.scan |-> !empty && (CW'(scan_idx) < count))
    else $error("scan past held entries");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> m_tvalid)
    else $error("result load lost");

endmodule
